### rtl/core/rpoc_pkg.sv
// rpoc_pkg: shared constants and types for the reprojection outlier check
// quaternion format, configuration register indexes and register reset values
// no dependencies
package rpoc_pkg;

    localparam int QUAT_WIDTH = 32;
    localparam int QUAT_FRAC = 30;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FOCAL_X     = 3'd0,
        CFG_FOCAL_Y     = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_ERROR_LIMIT = 3'd4
    } cfg_index_t;

    localparam logic [63:0] FOCAL_RESET    = 64'd32768000;
    localparam logic [63:0] CENTER_X_RESET = 64'd20971520;
    localparam logic [63:0] CENTER_Y_RESET = 64'd15728640;
    localparam logic [63:0] LIMIT_RESET    = 64'd392626;

endpackage

### rtl/core/reprojection_outlier_check.sv
// reprojection_outlier_check: pinhole reprojection error check, fully pipelined
// depends on rpoc_pkg for quaternion format, register indexes and reset values
//
// One observation (pose, world point, observed pixel) is accepted every clock
// cycle while no result is stalled at the output, and one result leaves per
// item in order. The pipe has seven stages of rotation, translation and
// intrinsics, one divider setup stage, one restoring quotient bit per stage
// for COORD_WIDTH + FRAC_BITS stages, and four stages for the error square
// and compare. The whole pipe halts while a result is stalled at the output.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while no item is in flight, which the block itself
// does not enforce. Writes to unknown indexes are dropped.
module reprojection_outlier_check #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [rpoc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]                  cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [COORD_WIDTH-1:0]           trans_x,
    input  logic signed [COORD_WIDTH-1:0]           trans_y,
    input  logic signed [COORD_WIDTH-1:0]           trans_z,
    input  logic signed [rpoc_pkg::QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [rpoc_pkg::QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [rpoc_pkg::QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [rpoc_pkg::QUAT_WIDTH-1:0]  quat_z,
    input  logic signed [COORD_WIDTH-1:0]           point_x,
    input  logic signed [COORD_WIDTH-1:0]           point_y,
    input  logic signed [COORD_WIDTH-1:0]           point_z,
    input  logic signed [COORD_WIDTH-1:0]           seen_u,
    input  logic signed [COORD_WIDTH-1:0]           seen_v,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    outlier,
    output logic [COORD_WIDTH-1:0]                  error_squared,
    output logic                                    depth_zero
);

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int QW = rpoc_pkg::QUAT_WIDTH;
    localparam int QF = rpoc_pkg::QUAT_FRAC;
    localparam int PW = W + QW;
    localparam int FW = 2 * W + 1;
    localparam int SW = 2 * W + QW;
    localparam int NB = W + F;
    localparam int QW2 = 2 * W + 2;
    localparam int LAT = NB + 12;

    localparam logic [NB-1:0] CAP_POS = {{(F + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [NB-1:0] CAP_NEG = {{F{1'b0}}, 1'b1, {(W - 1){1'b0}}};

    typedef struct packed {
        logic [W-1:0]  rem;
        logic [NB-1:0] num;
        logic [NB-1:0] quo;
    } div_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [W-1:0] r;
        if ((&v[SW-1:W-1]) || !(|v[SW-1:W-1]))
        begin
            r = v[W-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(W - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(W - 1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] prod_sat(input logic signed [SW-1:0] p,
                                                     input int sh);
        return sat_w(p >>> sh);
    endfunction

    function automatic logic signed [PW-1:0] mul_q(input logic signed [QW-1:0] q,
                                                   input logic signed [W-1:0] c);
        return PW'(q) * PW'(c);
    endfunction

    function automatic logic signed [FW-1:0] mul_f(input logic [W-1:0] k,
                                                   input logic signed [W-1:0] c);
        return FW'($signed({1'b0, k})) * FW'(c);
    endfunction

    function automatic div_t div_step(input div_t s, input logic [W-1:0] d);
        logic [W:0] sh;
        div_t r;
        sh = {s.rem, s.num[NB-1]};
        r.num = {s.num[NB-2:0], 1'b0};
        if (sh >= {1'b0, d})
        begin
            r.rem = W'(sh - {1'b0, d});
            r.quo = {s.quo[NB-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[W-1:0];
            r.quo = {s.quo[NB-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
        return v[W-1] ? W'(~v + 1'b1) : W'(v);
    endfunction

    function automatic logic signed [W:0] signed_quo(input logic [NB-1:0] quo,
                                                     input logic neg);
        logic [NB-1:0] cap;
        logic [NB-1:0] q;
        logic signed [W:0] r;
        cap = neg ? CAP_NEG : CAP_POS;
        q = (quo > cap) ? cap : quo;
        r = $signed((W + 1)'(q));
        return neg ? -r : r;
    endfunction

    function automatic logic [W:0] err_mag(input logic signed [W-1:0] s,
                                           input logic signed [W:0] d);
        logic signed [W+1:0] e;
        e = (W + 2)'(s) - (W + 2)'(d);
        return e[W+1] ? (W + 1)'(-e) : (W + 1)'(e);
    endfunction

    function automatic logic [W-1:0] sq_cap(input logic [QW2-1:0] sq);
        return (|sq[QW2-1:W+F]) ? {W{1'b1}} : sq[W+F-1:F];
    endfunction

    // configuration registers
    logic [W-1:0] focal_x_reg;
    logic [W-1:0] focal_y_reg;
    logic [W-1:0] center_x_reg;
    logic [W-1:0] center_y_reg;
    logic [W-1:0] error_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg     <= W'(rpoc_pkg::FOCAL_RESET);
            focal_y_reg     <= W'(rpoc_pkg::FOCAL_RESET);
            center_x_reg    <= W'(rpoc_pkg::CENTER_X_RESET);
            center_y_reg    <= W'(rpoc_pkg::CENTER_Y_RESET);
            error_limit_reg <= W'(rpoc_pkg::LIMIT_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rpoc_pkg::CFG_FOCAL_X:     focal_x_reg     <= cfg_data;
                rpoc_pkg::CFG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                rpoc_pkg::CFG_CENTER_X:    center_x_reg    <= cfg_data;
                rpoc_pkg::CFG_CENTER_Y:    center_y_reg    <= cfg_data;
                rpoc_pkg::CFG_ERROR_LIMIT: error_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [LAT-1:0] valid_reg;
    logic adv;

    assign adv = !(valid_reg[LAT-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    // stage 1: cross product terms
    logic signed [PW-1:0] p1_a_reg, p1_b_reg, p1_c_reg, p1_d_reg, p1_e_reg, p1_f_reg;
    logic signed [QW-1:0] s1_w_reg, s1_ux_reg, s1_uy_reg, s1_uz_reg;
    logic signed [W-1:0]  s1_vx_reg, s1_vy_reg, s1_vz_reg;
    logic signed [W-1:0]  s1_tx_reg, s1_ty_reg, s1_tz_reg, s1_su_reg, s1_sv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_a_reg  <= mul_q(quat_y, point_z);
            p1_b_reg  <= mul_q(quat_z, point_y);
            p1_c_reg  <= mul_q(quat_z, point_x);
            p1_d_reg  <= mul_q(quat_x, point_z);
            p1_e_reg  <= mul_q(quat_x, point_y);
            p1_f_reg  <= mul_q(quat_y, point_x);
            s1_w_reg  <= quat_w;
            s1_ux_reg <= quat_x;
            s1_uy_reg <= quat_y;
            s1_uz_reg <= quat_z;
            s1_vx_reg <= point_x;
            s1_vy_reg <= point_y;
            s1_vz_reg <= point_z;
            s1_tx_reg <= trans_x;
            s1_ty_reg <= trans_y;
            s1_tz_reg <= trans_z;
            s1_su_reg <= seen_u;
            s1_sv_reg <= seen_v;
        end
    end

    // stage 2: t = 2 (u x v)
    logic signed [W-1:0]  t2_x_reg, t2_y_reg, t2_z_reg;
    logic signed [QW-1:0] s2_w_reg, s2_ux_reg, s2_uy_reg, s2_uz_reg;
    logic signed [W-1:0]  s2_vx_reg, s2_vy_reg, s2_vz_reg;
    logic signed [W-1:0]  s2_tx_reg, s2_ty_reg, s2_tz_reg, s2_su_reg, s2_sv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_x_reg  <= sat_w(SW'(prod_sat(SW'(p1_a_reg), QF - 1))
                             - SW'(prod_sat(SW'(p1_b_reg), QF - 1)));
            t2_y_reg  <= sat_w(SW'(prod_sat(SW'(p1_c_reg), QF - 1))
                             - SW'(prod_sat(SW'(p1_d_reg), QF - 1)));
            t2_z_reg  <= sat_w(SW'(prod_sat(SW'(p1_e_reg), QF - 1))
                             - SW'(prod_sat(SW'(p1_f_reg), QF - 1)));
            s2_w_reg  <= s1_w_reg;
            s2_ux_reg <= s1_ux_reg;
            s2_uy_reg <= s1_uy_reg;
            s2_uz_reg <= s1_uz_reg;
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_vz_reg <= s1_vz_reg;
            s2_tx_reg <= s1_tx_reg;
            s2_ty_reg <= s1_ty_reg;
            s2_tz_reg <= s1_tz_reg;
            s2_su_reg <= s1_su_reg;
            s2_sv_reg <= s1_sv_reg;
        end
    end

    // stage 3: rotation products
    logic signed [PW-1:0] p3_xa_reg, p3_xb_reg, p3_xc_reg;
    logic signed [PW-1:0] p3_ya_reg, p3_yb_reg, p3_yc_reg;
    logic signed [PW-1:0] p3_za_reg, p3_zb_reg, p3_zc_reg;
    logic signed [W-1:0]  s3_vx_reg, s3_vy_reg, s3_vz_reg;
    logic signed [W-1:0]  s3_tx_reg, s3_ty_reg, s3_tz_reg, s3_su_reg, s3_sv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_xa_reg <= mul_q(s2_w_reg, t2_x_reg);
            p3_xb_reg <= mul_q(s2_uy_reg, t2_z_reg);
            p3_xc_reg <= mul_q(s2_uz_reg, t2_y_reg);
            p3_ya_reg <= mul_q(s2_w_reg, t2_y_reg);
            p3_yb_reg <= mul_q(s2_uz_reg, t2_x_reg);
            p3_yc_reg <= mul_q(s2_ux_reg, t2_z_reg);
            p3_za_reg <= mul_q(s2_w_reg, t2_z_reg);
            p3_zb_reg <= mul_q(s2_ux_reg, t2_y_reg);
            p3_zc_reg <= mul_q(s2_uy_reg, t2_x_reg);
            s3_vx_reg <= s2_vx_reg;
            s3_vy_reg <= s2_vy_reg;
            s3_vz_reg <= s2_vz_reg;
            s3_tx_reg <= s2_tx_reg;
            s3_ty_reg <= s2_ty_reg;
            s3_tz_reg <= s2_tz_reg;
            s3_su_reg <= s2_su_reg;
            s3_sv_reg <= s2_sv_reg;
        end
    end

    // stage 4: rotated point
    logic signed [W-1:0] r4_x_reg, r4_y_reg, r4_z_reg;
    logic signed [W-1:0] s4_tx_reg, s4_ty_reg, s4_tz_reg, s4_su_reg, s4_sv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r4_x_reg  <= sat_w(SW'(s3_vx_reg) + SW'(prod_sat(SW'(p3_xa_reg), QF))
                             + SW'(prod_sat(SW'(p3_xb_reg), QF))
                             - SW'(prod_sat(SW'(p3_xc_reg), QF)));
            r4_y_reg  <= sat_w(SW'(s3_vy_reg) + SW'(prod_sat(SW'(p3_ya_reg), QF))
                             + SW'(prod_sat(SW'(p3_yb_reg), QF))
                             - SW'(prod_sat(SW'(p3_yc_reg), QF)));
            r4_z_reg  <= sat_w(SW'(s3_vz_reg) + SW'(prod_sat(SW'(p3_za_reg), QF))
                             + SW'(prod_sat(SW'(p3_zb_reg), QF))
                             - SW'(prod_sat(SW'(p3_zc_reg), QF)));
            s4_tx_reg <= s3_tx_reg;
            s4_ty_reg <= s3_ty_reg;
            s4_tz_reg <= s3_tz_reg;
            s4_su_reg <= s3_su_reg;
            s4_sv_reg <= s3_sv_reg;
        end
    end

    // stage 5: camera point
    logic signed [W-1:0] c5_x_reg, c5_y_reg, c5_z_reg, s5_su_reg, s5_sv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c5_x_reg  <= sat_w(SW'(r4_x_reg) + SW'(s4_tx_reg));
            c5_y_reg  <= sat_w(SW'(r4_y_reg) + SW'(s4_ty_reg));
            c5_z_reg  <= sat_w(SW'(r4_z_reg) + SW'(s4_tz_reg));
            s5_su_reg <= s4_su_reg;
            s5_sv_reg <= s4_sv_reg;
        end
    end

    // stage 6: intrinsics products
    logic signed [FW-1:0] p6_fu_reg, p6_cu_reg, p6_fv_reg, p6_cv_reg;
    logic signed [W-1:0]  s6_cz_reg, s6_su_reg, s6_sv_reg;
    logic                 s6_zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_fu_reg   <= mul_f(focal_x_reg, c5_x_reg);
            p6_cu_reg   <= mul_f(center_x_reg, c5_z_reg);
            p6_fv_reg   <= mul_f(focal_y_reg, c5_y_reg);
            p6_cv_reg   <= mul_f(center_y_reg, c5_z_reg);
            s6_cz_reg   <= c5_z_reg;
            s6_zero_reg <= (c5_z_reg == '0);
            s6_su_reg   <= s5_su_reg;
            s6_sv_reg   <= s5_sv_reg;
        end
    end

    // stage 7: pixel numerators
    logic signed [W-1:0] n7_u_reg, n7_v_reg, s7_cz_reg, s7_su_reg, s7_sv_reg;
    logic                s7_zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n7_u_reg    <= sat_w(SW'(prod_sat(SW'(p6_fu_reg), F))
                               + SW'(prod_sat(SW'(p6_cu_reg), F)));
            n7_v_reg    <= sat_w(SW'(prod_sat(SW'(p6_fv_reg), F))
                               + SW'(prod_sat(SW'(p6_cv_reg), F)));
            s7_cz_reg   <= s6_cz_reg;
            s7_zero_reg <= s6_zero_reg;
            s7_su_reg   <= s6_su_reg;
            s7_sv_reg   <= s6_sv_reg;
        end
    end

    // divider: setup at entry 0, one quotient bit per following entry
    div_t                div_u_reg [0:NB];
    div_t                div_v_reg [0:NB];
    logic [W-1:0]        dden_reg  [0:NB];
    logic                dneg_u_reg [0:NB];
    logic                dneg_v_reg [0:NB];
    logic                dzero_reg [0:NB];
    logic signed [W-1:0] dsu_reg   [0:NB];
    logic signed [W-1:0] dsv_reg   [0:NB];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_u_reg[0]  <= '{rem: '0, num: {abs_w(n7_u_reg), {F{1'b0}}}, quo: '0};
            div_v_reg[0]  <= '{rem: '0, num: {abs_w(n7_v_reg), {F{1'b0}}}, quo: '0};
            dden_reg[0]   <= abs_w(s7_cz_reg);
            dneg_u_reg[0] <= n7_u_reg[W-1] ^ s7_cz_reg[W-1];
            dneg_v_reg[0] <= n7_v_reg[W-1] ^ s7_cz_reg[W-1];
            dzero_reg[0]  <= s7_zero_reg;
            dsu_reg[0]    <= s7_su_reg;
            dsv_reg[0]    <= s7_sv_reg;
            for (int k = 1; k <= NB; k++)
            begin
                div_u_reg[k]  <= div_step(div_u_reg[k-1], dden_reg[k-1]);
                div_v_reg[k]  <= div_step(div_v_reg[k-1], dden_reg[k-1]);
                dden_reg[k]   <= dden_reg[k-1];
                dneg_u_reg[k] <= dneg_u_reg[k-1];
                dneg_v_reg[k] <= dneg_v_reg[k-1];
                dzero_reg[k]  <= dzero_reg[k-1];
                dsu_reg[k]    <= dsu_reg[k-1];
                dsv_reg[k]    <= dsv_reg[k-1];
            end
        end
    end

    // error stages
    logic signed [W:0]   e1_du_reg, e1_dv_reg;
    logic signed [W-1:0] e1_su_reg, e1_sv_reg;
    logic                e1_zero_reg;
    logic [W:0]          e2_mu_reg, e2_mv_reg;
    logic                e2_zero_reg;
    logic [QW2-1:0]      e3_qu_reg, e3_qv_reg;
    logic                e3_zero_reg;
    logic [W:0]          err_sum;
    logic [W-1:0]        err_next;
    logic                outlier_reg;
    logic [W-1:0]        error_reg;
    logic                zero_reg;

    assign err_sum = (W + 1)'(sq_cap(e3_qu_reg)) + (W + 1)'(sq_cap(e3_qv_reg));
    assign err_next = err_sum[W] ? {W{1'b1}} : err_sum[W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_du_reg   <= signed_quo(div_u_reg[NB].quo, dneg_u_reg[NB]);
            e1_dv_reg   <= signed_quo(div_v_reg[NB].quo, dneg_v_reg[NB]);
            e1_su_reg   <= dsu_reg[NB];
            e1_sv_reg   <= dsv_reg[NB];
            e1_zero_reg <= dzero_reg[NB];
            e2_mu_reg   <= err_mag(e1_su_reg, e1_du_reg);
            e2_mv_reg   <= err_mag(e1_sv_reg, e1_dv_reg);
            e2_zero_reg <= e1_zero_reg;
            e3_qu_reg   <= QW2'(e2_mu_reg) * QW2'(e2_mu_reg);
            e3_qv_reg   <= QW2'(e2_mv_reg) * QW2'(e2_mv_reg);
            e3_zero_reg <= e2_zero_reg;
            if (e3_zero_reg)
            begin
                outlier_reg <= 1'b1;
                error_reg   <= {W{1'b1}};
                zero_reg    <= 1'b1;
            end
            else
            begin
                outlier_reg <= (err_next > error_limit_reg);
                error_reg   <= err_next;
                zero_reg    <= 1'b0;
            end
        end
    end

    assign outlier = outlier_reg;
    assign error_squared = error_reg;
    assign depth_zero = zero_reg;

endmodule
